// ----- design/m6502s_pkg.sv -----
// Package with the shared types and instruction codes of the 6502-subset step core.
package m6502s_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EXEC = 1'b1;

	localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OP_LSR_A   = 8'h4A;
	localparam logic [7:0] OP_EOR_IMM = 8'h49;
	localparam logic [7:0] OP_STA_ZP  = 8'h85;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_DEX     = 8'hCA;
	localparam logic [7:0] OP_BNE     = 8'hD0;
	localparam logic [7:0] OP_DEY     = 8'h88;
	localparam logic [7:0] OP_JMP_ABS = 8'h4C;

	localparam logic [7:0] COLOUR_ADDR_A = 8'h08;
	localparam logic [7:0] COLOUR_ADDR_B = 8'h09;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OP,
		ST_B1,
		ST_DATA
	} seq_state_t;

	typedef struct packed {
		logic        rd_en;
		logic [15:0] rd_addr;
		logic        wr_en;
		logic [15:0] wr_addr;
		logic [7:0]  wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] program_counter;
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic        carry_flag;
		logic        zero_flag;
		logic [7:0]  background_colour;
		logic        unsupported;
	} result_t;

endpackage

// ----- design/m6502s_mem.sv -----
// Byte memory with one write port and one registered read port.
module m6502s_mem #(
	parameter int unsigned MEM_DEPTH = 4096
) (
	input  logic                 clk,
	input  m6502s_pkg::mem_req_t req,
	output logic [7:0]           rd_data
);
	localparam int unsigned AW = $clog2(MEM_DEPTH);

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/m6502s_seq.sv -----
// Instruction sequencer with the architectural registers and the memory clearing pass.
module m6502s_seq #(
	parameter int unsigned MEM_DEPTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 buf_valid,
	input  logic                 buf_cmd,
	input  logic [11:0]          buf_addr,
	input  logic [7:0]           buf_data,
	input  logic                 out_free,
	input  logic [7:0]           rd_data,
	output logic                 buf_pop,
	output logic                 clearing,
	output m6502s_pkg::mem_req_t req,
	output logic                 commit,
	output m6502s_pkg::result_t  res
);
	import m6502s_pkg::*;

	localparam int unsigned AW = $clog2(MEM_DEPTH);

	seq_state_t    state_q;
	seq_state_t    state_d;
	logic [AW-1:0] clr_q;
	logic          clr_last;
	result_t       arch_q;
	logic [7:0]    op_q;
	logic [7:0]    b1_q;
	logic          is_long;
	logic [15:0]   pc_inc1;
	logic [15:0]   pc_inc2;
	logic [7:0]    val;

	assign clr_last = (clr_q == AW'(MEM_DEPTH - 1));
	assign is_long  = (op_q == OP_LDA_ZP) || (op_q == OP_JMP_ABS);
	assign pc_inc1  = arch_q.program_counter + 16'd1;
	assign pc_inc2  = arch_q.program_counter + 16'd2;
	assign clearing = (state_q == ST_CLEAR);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (buf_valid && (buf_cmd == CMD_EXEC)) begin
					state_d = ST_OP;
				end
			end
			ST_OP: begin
				state_d = ST_B1;
			end
			ST_B1: begin
				if (is_long) begin
					state_d = ST_DATA;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DATA: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res             = arch_q;
		res.unsupported = 1'b0;
		commit          = 1'b0;
		buf_pop         = 1'b0;
		req             = '0;
		val             = 8'h00;
		unique case (state_q)
			ST_CLEAR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = 16'(clr_q);
				req.wr_data = 8'h00;
			end
			ST_IDLE: begin
				if (buf_valid) begin
					if (buf_cmd == CMD_LOAD) begin
						if (out_free) begin
							buf_pop             = 1'b1;
							commit              = 1'b1;
							req.wr_en           = 1'b1;
							req.wr_addr         = 16'(buf_addr);
							req.wr_data         = buf_data;
							res.program_counter = 16'h0000;
						end
					end else begin
						buf_pop     = 1'b1;
						req.rd_en   = 1'b1;
						req.rd_addr = arch_q.program_counter;
					end
				end
			end
			ST_OP: begin
				req.rd_en   = 1'b1;
				req.rd_addr = pc_inc1;
			end
			ST_B1: begin
				if (is_long) begin
					req.rd_en   = 1'b1;
					req.rd_addr = (op_q == OP_JMP_ABS) ? pc_inc2 : {8'h00, rd_data};
				end else if (out_free) begin
					commit              = 1'b1;
					res.program_counter = pc_inc2;
					unique case (op_q)
						OP_LSR_A: begin
							val                 = {1'b0, arch_q.accumulator[7:1]};
							res.carry_flag      = arch_q.accumulator[0];
							res.accumulator     = val;
							res.zero_flag       = (val == 8'h00);
							res.program_counter = pc_inc1;
						end
						OP_EOR_IMM: begin
							val             = arch_q.accumulator ^ rd_data;
							res.accumulator = val;
							res.zero_flag   = (val == 8'h00);
						end
						OP_STA_ZP: begin
							req.wr_en   = 1'b1;
							req.wr_addr = {8'h00, rd_data};
							req.wr_data = arch_q.accumulator;
							if ((rd_data == COLOUR_ADDR_A) || (rd_data == COLOUR_ADDR_B)) begin
								res.background_colour = arch_q.accumulator;
							end
						end
						OP_LDY_IMM: begin
							res.index_y   = rd_data;
							res.zero_flag = (rd_data == 8'h00);
						end
						OP_LDX_IMM: begin
							res.index_x   = rd_data;
							res.zero_flag = (rd_data == 8'h00);
						end
						OP_DEX: begin
							val                 = arch_q.index_x - 8'd1;
							res.index_x         = val;
							res.zero_flag       = (val == 8'h00);
							res.program_counter = pc_inc1;
						end
						OP_DEY: begin
							val                 = arch_q.index_y - 8'd1;
							res.index_y         = val;
							res.zero_flag       = (val == 8'h00);
							res.program_counter = pc_inc1;
						end
						OP_BNE: begin
							if (!arch_q.zero_flag) begin
								res.program_counter = pc_inc2 + {{8{rd_data[7]}}, rd_data};
							end
						end
						default: begin
							res.unsupported     = 1'b1;
							res.program_counter = pc_inc1;
						end
					endcase
				end
			end
			ST_DATA: begin
				if (out_free) begin
					commit = 1'b1;
					if (op_q == OP_JMP_ABS) begin
						res.program_counter = {rd_data, b1_q};
					end else begin
						res.accumulator     = rd_data;
						res.zero_flag       = (rd_data == 8'h00);
						res.program_counter = pc_inc2;
					end
				end
			end
			default: begin
				res = arch_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			arch_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				arch_q <= res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OP) begin
			op_q <= rd_data;
		end
		if (state_q == ST_B1) begin
			b1_q <= rd_data;
		end
	end

endmodule

// ----- design/mini_6502_instruction_step_core.sv -----
// Top level of the 6502-subset step core: input buffer, sequencer, memory and result register.
//
// Channel | Handshake                  | Payload
// item    | item_valid / item_ready    | opcode, load_address, load_data
// result  | result_valid / result_ready| program_counter .. unsupported
//
// A load transaction is done in the idle state; an instruction passes through ST_IDLE, ST_OP,
// ST_B1 and, for LDA zero page and JMP absolute, ST_DATA, reading on the single read port.
// After reset a clearing pass writes zero to all MEM_DEPTH bytes, one per cycle,
// and item_ready stays low throughout the pass.
// One item waits in the input buffer while the sequencer works on another.
// A stalled result holds in the output register; the sequencer then waits at its last step.
// MEM_DEPTH is a power of two; addresses wrap modulo MEM_DEPTH.
module mini_6502_instruction_step_core #(
	parameter int unsigned MEM_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        opcode,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] program_counter,
	output logic [7:0]  accumulator,
	output logic [7:0]  index_x,
	output logic [7:0]  index_y,
	output logic        carry_flag,
	output logic        zero_flag,
	output logic [7:0]  background_colour,
	output logic        unsupported
);
	import m6502s_pkg::*;

	logic        buf_valid_q;
	logic        buf_cmd_q;
	logic [11:0] buf_addr_q;
	logic [7:0]  buf_data_q;
	logic        buf_pop;
	logic        clearing;
	logic        out_free;
	logic        commit;
	logic        res_valid_q;
	result_t     res;
	result_t     res_q;
	mem_req_t    req;
	logic [7:0]  rd_data;
	logic        item_take;

	assign item_ready = !clearing && (!buf_valid_q || buf_pop);
	assign item_take  = item_valid && item_ready;
	assign out_free   = !res_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				buf_valid_q <= 1'b1;
			end else if (buf_pop) begin
				buf_valid_q <= 1'b0;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			buf_cmd_q  <= opcode;
			buf_addr_q <= load_address;
			buf_data_q <= load_data;
		end
		if (commit) begin
			res_q <= res;
		end
	end

	m6502s_seq #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.buf_valid(buf_valid_q),
		.buf_cmd  (buf_cmd_q),
		.buf_addr (buf_addr_q),
		.buf_data (buf_data_q),
		.out_free (out_free),
		.rd_data  (rd_data),
		.buf_pop  (buf_pop),
		.clearing (clearing),
		.req      (req),
		.commit   (commit),
		.res      (res)
	);

	m6502s_mem #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_mem (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

	assign result_valid      = res_valid_q;
	assign program_counter   = res_q.program_counter;
	assign accumulator       = res_q.accumulator;
	assign index_x           = res_q.index_x;
	assign index_y           = res_q.index_y;
	assign carry_flag        = res_q.carry_flag;
	assign zero_flag         = res_q.zero_flag;
	assign background_colour = res_q.background_colour;
	assign unsupported       = res_q.unsupported;

endmodule

// ----- design/m6502s_chk.sv -----
// Port-level checker of the 6502-subset step core and its bind to the top level.
module m6502s_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] program_counter,
	input logic [7:0]  accumulator,
	input logic        unsupported
);
	logic [2:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'((item_valid && item_ready) ? 1 : 0)
				- 3'((result_valid && result_ready) ? 1 : 0);
		end
	end

	// A transaction is not taken in the first cycle after reset, while memory is cleared.
	a_no_take_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !item_ready)
		else $error("item_ready high during the memory clearing pass");

	// Every result belongs to an accepted item that has not yet been answered.
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pending_q != 3'd0))
		else $error("result shown without an outstanding item");

	// At most three items are inside the block: buffer, sequencer and output register.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more items outstanding than the block can hold");

	// A stalled result holds its program counter, accumulator and unsupported flag.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(program_counter)
			&& $stable(accumulator) && $stable(unsupported))
		else $error("stalled result changed");

endmodule

bind mini_6502_instruction_step_core m6502s_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.program_counter(program_counter),
	.accumulator    (accumulator),
	.unsupported    (unsupported)
);
